/* hw/rtl/itm_pkg.sv */
// Package for the inch token parser: sizing constants, character codes and
// the token word handed from the scanner to the conversion pipeline.
// No dependencies.
package itm_pkg;

    // Token limits
    localparam int INT_DIGITS  = 6;
    localparam int FRAC_DIGITS = 4;

    // Return 10 to the power e, for elaboration-time sizing
    function automatic longint unsigned pow10(input int e);
        longint unsigned r;
        r = 64'd1;
        for (int i = 0; i < e; i++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    localparam longint unsigned SCALE     = pow10(FRAC_DIGITS);
    localparam longint unsigned WHOLE_LIM = pow10(INT_DIGITS);

    localparam int WHOLE_W = $clog2(WHOLE_LIM);
    localparam int ICNT_W  = $clog2(INT_DIGITS + 1);
    localparam int FRAC_W  = $clog2(SCALE);
    localparam int FCNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam int CHAR_W  = 8;
    localparam int OUT_W   = 32;

    // Hundredths of a millimetre per inch
    localparam longint unsigned MM_PER_IN = 2540;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    // Finished token: integer part, kept fraction digits and their count
    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [FCNT_W-1:0]  fcnt;
    } t_token;

endpackage

/* hw/rtl/inch_token_to_mm_parser.sv */
// Inch token parser: scans one character per word for tokens N[.F]in and
// emits the length in hundredths of a millimetre when a separator ends one.
// Depends on itm_pkg and itm_conv.
// Throughput: one character per cycle while the converter is ready. A result
// word passes through the five register stages of the conversion pipeline
// after the separator that ends its token is accepted. Synchronous active-low
// reset returns the scanner to its start state and empties the pipeline.
module inch_token_to_mm_parser
    import itm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_char_code,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_mm_hundredths
);

    typedef enum logic [5:0] {
        ST_START = 6'b000001,
        ST_INT   = 6'b000010,
        ST_FRAC  = 6'b000100,
        ST_I     = 6'b001000,
        ST_N     = 6'b010000,
        ST_SKIP  = 6'b100000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic [ICNT_W-1:0]  r_icnt,  n_icnt;
    logic [FRAC_W-1:0]  r_frac,  n_frac;
    logic [FCNT_W-1:0]  r_fcnt,  n_fcnt;

    logic              accept;
    logic              is_sep;
    logic              is_dig;
    logic [3:0]        dig_val;
    logic              conv_ready;
    logic              tok_valid;
    t_token            tok;

    assign accept  = i_valid && conv_ready;
    assign o_ready = conv_ready;
    assign is_sep  = (i_char_code == CH_SPACE) || (i_char_code == CH_LF);
    assign is_dig  = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign dig_val = is_dig ? 4'(i_char_code - CH_ZERO) : 4'd0;

    // Hand a finished token to the converter
    assign tok_valid = accept && is_sep && (r_phase == ST_N);
    assign tok.whole = r_whole;
    assign tok.frac  = r_frac;
    assign tok.fcnt  = r_fcnt;

    // Scanner next state
    always_comb begin
        n_phase = r_phase;
        n_whole = r_whole;
        n_icnt  = r_icnt;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        if (is_sep) begin
            n_phase = ST_START;
        end else begin
            case (r_phase)
                ST_START: begin
                    if (is_dig && (i_char_code >= CH_ONE)) begin
                        n_whole = WHOLE_W'(dig_val);
                        n_icnt  = ICNT_W'(1);
                        n_phase = ST_INT;
                    end else begin
                        n_phase = ST_SKIP;
                    end
                end
                ST_INT: begin
                    if (is_dig) begin
                        if (r_icnt < ICNT_W'(INT_DIGITS)) begin
                            n_whole = WHOLE_W'(r_whole * WHOLE_W'(10)) + WHOLE_W'(dig_val);
                            n_icnt  = r_icnt + ICNT_W'(1);
                        end else begin
                            n_phase = ST_SKIP;
                        end
                    end else if (i_char_code == CH_DOT) begin
                        n_phase = ST_FRAC;
                    end else if (i_char_code == CH_I) begin
                        n_phase = ST_I;
                    end else begin
                        n_phase = ST_SKIP;
                    end
                end
                ST_FRAC: begin
                    if (is_dig) begin
                        // Drop digits past the kept precision
                        if (r_fcnt < FCNT_W'(FRAC_DIGITS)) begin
                            n_frac = FRAC_W'(r_frac * FRAC_W'(10)) + FRAC_W'(dig_val);
                            n_fcnt = r_fcnt + FCNT_W'(1);
                        end
                    end else if (i_char_code == CH_I) begin
                        n_phase = ST_I;
                    end else begin
                        n_phase = ST_SKIP;
                    end
                end
                ST_I: begin
                    n_phase = (i_char_code == CH_N) ? ST_N : ST_SKIP;
                end
                default: begin
                    n_phase = ST_SKIP;
                end
            endcase
        end
        // Clear the token on a separator or an invalid character
        if (is_sep || (n_phase == ST_SKIP)) begin
            n_whole = '0;
            n_icnt  = '0;
            n_frac  = '0;
            n_fcnt  = '0;
        end
    end

    // Scanner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_START;
            r_whole <= '0;
            r_icnt  <= '0;
            r_frac  <= '0;
            r_fcnt  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_whole <= n_whole;
            r_icnt  <= n_icnt;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
        end
    end

    // Conversion pipeline
    itm_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tok_valid),
        .o_ready (conv_ready),
        .i_token (tok),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_mm    (o_mm_hundredths)
    );

endmodule

/* hw/rtl/itm_conv.sv */
// Conversion pipeline: finished inch token to hundredths of a millimetre,
// rounded half up, saturated to 32 bits. Five register stages with valid/ready.
// Depends on itm_pkg.
module itm_conv
    import itm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_token           i_token,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_mm
);

    localparam int              SCALE_W = $clog2(SCALE + 1);
    localparam int              PF_W    = FRAC_W + SCALE_W;
    localparam int              WMM_W   = $clog2(WHOLE_LIM * MM_PER_IN);
    localparam int              X_W     = $clog2((MM_PER_IN + 1) * SCALE);
    localparam int              K_SH    = $clog2((MM_PER_IN + 1) * SCALE * SCALE) + 1;
    localparam longint unsigned RECIP   = ((64'd1 << K_SH) + SCALE - 1) / SCALE;
    localparam int              M_W     = $clog2(RECIP + 1);
    localparam int              P_W     = X_W + M_W;
    localparam int              Q_W     = $clog2(MM_PER_IN + 1);
    localparam int              S_W     = WMM_W + 1;

    // Stage valid bits and advance enables
    logic r_va, r_vb, r_vc, r_vd, r_ve;
    logic en_a, en_b, en_c, en_d, en_e;

    // Stage payloads
    logic [WHOLE_W-1:0] r_whole;
    logic [FRAC_W-1:0]  r_frac;
    logic [FCNT_W-1:0]  r_fcnt;
    logic [WMM_W-1:0]   r_wmm_b, r_wmm_c, r_wmm_d;
    logic [FRAC_W-1:0]  r_fa;
    logic [X_W-1:0]     r_x;
    logic [P_W-1:0]     r_p;
    logic [OUT_W-1:0]   r_mm;

    logic [SCALE_W-1:0] pow_tab [FRAC_DIGITS+1];
    logic [FCNT_W-1:0]  missing;
    logic [PF_W-1:0]    frac_prod;
    logic [WMM_W-1:0]   n_wmm;
    logic [FRAC_W-1:0]  n_fa;
    logic [X_W-1:0]     n_x;
    logic [P_W-1:0]     n_p;
    logic [Q_W-1:0]     q_frac;
    logic [S_W-1:0]     sum;
    logic [OUT_W-1:0]   n_mm;

    // Advance a stage when it is empty or the next one advances
    assign en_e    = !r_ve || i_ready;
    assign en_d    = !r_vd || en_e;
    assign en_c    = !r_vc || en_d;
    assign en_b    = !r_vb || en_c;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_ve;
    assign o_mm    = r_mm;

    // Powers of ten that align the kept fraction digits
    always_comb begin
        for (int i = 0; i <= FRAC_DIGITS; i++) begin
            pow_tab[i] = SCALE_W'(pow10(i));
        end
    end

    // Stage B: whole part in mm, fraction aligned to full scale
    assign missing   = FCNT_W'(FRAC_DIGITS) - r_fcnt;
    assign frac_prod = PF_W'(r_frac) * PF_W'(pow_tab[missing]);
    assign n_fa      = frac_prod[FRAC_W-1:0];
    assign n_wmm     = WMM_W'(r_whole) * WMM_W'(MM_PER_IN);

    // Stage C: fraction times 2540 plus half a unit for rounding
    assign n_x = X_W'(r_fa) * X_W'(MM_PER_IN) + X_W'(SCALE / 2);

    // Stage D: divide by the scale through a reciprocal multiply
    assign n_p = P_W'(r_x) * P_W'(RECIP);

    // Stage E: combine and saturate
    assign q_frac = Q_W'(r_p >> K_SH);
    assign sum    = S_W'(r_wmm_d) + S_W'(q_frac);
    assign n_mm   = (sum > S_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(sum);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (en_d) r_vd <= r_vc;
            if (en_e) r_ve <= r_vd;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_whole <= i_token.whole;
            r_frac  <= i_token.frac;
            r_fcnt  <= i_token.fcnt;
        end
        if (en_b) begin
            r_wmm_b <= n_wmm;
            r_fa    <= n_fa;
        end
        if (en_c) begin
            r_wmm_c <= r_wmm_b;
            r_x     <= n_x;
        end
        if (en_d) begin
            r_wmm_d <= r_wmm_c;
            r_p     <= n_p;
        end
        if (en_e) begin
            r_mm <= n_mm;
        end
    end

endmodule
